FILE: hw/rtl/bsm_pkg.sv
package bsm_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned InDataWidth = 120;
  localparam int unsigned OutDataWidth = 56;

  localparam logic [2:0] RegOverheatThreshold  = 3'd0;
  localparam logic [2:0] RegClampMaxPressure   = 3'd1;
  localparam logic [2:0] RegVoltMin            = 3'd2;
  localparam logic [2:0] RegVoltMax            = 3'd3;
  localparam logic [2:0] RegForceThreshold     = 3'd4;
  localparam logic [2:0] RegRecoverySamples    = 3'd5;
  localparam logic [2:0] RegPlausibilitySamples = 3'd6;

  localparam logic signed [15:0] OverheatThresholdRst = 16'sd2400;
  localparam logic [15:0] ClampMaxPressureRst   = 16'd12800;
  localparam logic [15:0] VoltMinRst            = 16'd500;
  localparam logic [15:0] VoltMaxRst            = 16'd4500;
  localparam logic [15:0] ForceThresholdRst     = 16'd12800;
  localparam logic [7:0]  RecoverySamplesRst    = 8'd3;
  localparam logic [7:0]  PlausibilitySamplesRst = 8'd5;

  localparam logic [7:0] ThermalBit  = 8'h02;
  localparam logic [7:0] PlausBit    = 8'h10;
  localparam logic [7:0] FailSafeBit = 8'h40;
  localparam logic [7:0] CountMax    = 8'hff;

  typedef struct packed {
    logic signed [15:0] overheat_threshold;
    logic [15:0]        clamp_max_pressure;
    logic [15:0]        volt_min;
    logic [15:0]        volt_max;
    logic [15:0]        force_threshold;
    logic [7:0]         recovery_samples;
    logic [7:0]         plausibility_samples;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         status_in;
    logic [15:0]        rear_in;
    logic [15:0]        front_in;
    logic [15:0]        pressure_in;
    logic [15:0]        sensor_mv;
    logic [15:0]        foot_force;
    logic [15:0]        speed;
    logic signed [15:0] brake_temp;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  status_out;
    logic [15:0] rear_out;
    logic [15:0] front_out;
    logic [15:0] pressure_out;
  } out_item_t;

endpackage

FILE: hw/rtl/bsm_apb_regs.sv
module bsm_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsm_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output bsm_pkg::cfg_t                  cfg_o
);
  import bsm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegOverheatThreshold:   cfg_d.overheat_threshold   = signed'(pwdata[15:0]);
        RegClampMaxPressure:    cfg_d.clamp_max_pressure   = pwdata[15:0];
        RegVoltMin:             cfg_d.volt_min             = pwdata[15:0];
        RegVoltMax:             cfg_d.volt_max             = pwdata[15:0];
        RegForceThreshold:      cfg_d.force_threshold      = pwdata[15:0];
        RegRecoverySamples:     cfg_d.recovery_samples     = pwdata[7:0];
        RegPlausibilitySamples: cfg_d.plausibility_samples = pwdata[7:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegOverheatThreshold:   prdata = {16'd0, cfg_q.overheat_threshold};
      RegClampMaxPressure:    prdata = {16'd0, cfg_q.clamp_max_pressure};
      RegVoltMin:             prdata = {16'd0, cfg_q.volt_min};
      RegVoltMax:             prdata = {16'd0, cfg_q.volt_max};
      RegForceThreshold:      prdata = {16'd0, cfg_q.force_threshold};
      RegRecoverySamples:     prdata = {24'd0, cfg_q.recovery_samples};
      RegPlausibilitySamples: prdata = {24'd0, cfg_q.plausibility_samples};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overheat_threshold   <= OverheatThresholdRst;
      cfg_q.clamp_max_pressure   <= ClampMaxPressureRst;
      cfg_q.volt_min             <= VoltMinRst;
      cfg_q.volt_max             <= VoltMaxRst;
      cfg_q.force_threshold      <= ForceThresholdRst;
      cfg_q.recovery_samples     <= RecoverySamplesRst;
      cfg_q.plausibility_samples <= PlausibilitySamplesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/brake_safety_monitor_top.sv
// Channel   | Direction | Contents
// s_axis    | in        | one sensor sample per transfer
// m_axis    | out       | one result per sample
// apb       | in/out    | seven threshold and count registers at 4*i
//
// One item per cycle sustained while m_axis_tready is high; path: input register, result register.
// Latches and counters update as a sample moves from the input register to the result register.
// rst_ni clears all latches, counters, previous speed and loads register defaults.
// A stall on m_axis holds the result register and a full input register; s_axis_tready drops only when both are full.
module brake_safety_monitor_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // brake_temp, speed, foot_force, sensor_mv, pressure_in, front_in, rear_in, status_in
  input  logic [bsm_pkg::InDataWidth-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pressure_out, front_out, rear_out, status_out
  output logic [bsm_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsm_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bsm_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  out_item_t out_q, out_d;
  logic      in_valid_q, out_valid_q;
  logic      advance, move;

  logic [15:0] prev_speed_q, prev_speed_d;
  logic [7:0]  plaus_cnt_q, plaus_cnt_d;
  logic        plaus_latch_q, plaus_latch_d;
  logic        therm_latch_q, therm_latch_d;
  logic [7:0]  cool_cnt_q, cool_cnt_d;

  logic        hot, fail, plaus_cond;
  logic [7:0]  cool_inc, plaus_inc;
  logic [15:0] p_main;

  bsm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign move          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    hot        = in_q.brake_temp > cfg.overheat_threshold;
    cool_inc   = (cool_cnt_q != CountMax) ? cool_cnt_q + 8'd1 : cool_cnt_q;
    plaus_inc  = (plaus_cnt_q != CountMax) ? plaus_cnt_q + 8'd1 : plaus_cnt_q;
    plaus_cond = (in_q.speed >= prev_speed_q) && (in_q.foot_force > cfg.force_threshold);
    fail       = (in_q.sensor_mv < cfg.volt_min) || (in_q.sensor_mv > cfg.volt_max);

    therm_latch_d = therm_latch_q;
    cool_cnt_d    = cool_cnt_q;
    if (hot) begin
      therm_latch_d = 1'b1;
      cool_cnt_d    = 8'd0;
    end else if (therm_latch_q) begin
      cool_cnt_d    = cool_inc;
      therm_latch_d = !(cool_inc >= cfg.recovery_samples);
    end

    if (plaus_cond) begin
      plaus_cnt_d   = plaus_inc;
      plaus_latch_d = plaus_latch_q || (plaus_inc >= cfg.plausibility_samples);
    end else begin
      plaus_cnt_d   = 8'd0;
      plaus_latch_d = 1'b0;
    end
    prev_speed_d = in_q.speed;

    p_main = in_q.pressure_in;
    if (therm_latch_d && (in_q.pressure_in > cfg.clamp_max_pressure)) begin
      p_main = cfg.clamp_max_pressure;
    end

    out_d.status_out = in_q.status_in
                     | (therm_latch_d ? ThermalBit : 8'd0)
                     | (plaus_latch_d ? PlausBit : 8'd0)
                     | (fail ? FailSafeBit : 8'd0);
    out_d.pressure_out = fail ? 16'd0 : p_main;
    out_d.front_out    = fail ? 16'd0 : in_q.front_in;
    out_d.rear_out     = fail ? 16'd0 : in_q.rear_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      prev_speed_q  <= 16'd0;
      plaus_cnt_q   <= 8'd0;
      plaus_latch_q <= 1'b0;
      therm_latch_q <= 1'b0;
      cool_cnt_q    <= 8'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (move) begin
        prev_speed_q  <= prev_speed_d;
        plaus_cnt_q   <= plaus_cnt_d;
        plaus_latch_q <= plaus_latch_d;
        therm_latch_q <= therm_latch_d;
        cool_cnt_q    <= cool_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_item_t'(s_axis_tdata);
    end
    if (move) begin
      out_q <= out_d;
    end
  end

  a_hot_sets_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && hot |=> therm_latch_q && (cool_cnt_q == 8'd0))
    else $error("thermal latch not set after overtemperature");

  a_plaus_latch_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plaus_latch_q |-> plaus_cnt_q != 8'd0)
    else $error("plausibility latch set with zero count");

  a_failsafe_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && fail |=> (out_q.pressure_out == 16'd0) && (out_q.front_out == 16'd0)
                     && (out_q.rear_out == 16'd0) && ((out_q.status_out & FailSafeBit) != 8'd0))
    else $error("fail-safe result carries pressure");

  a_prev_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> prev_speed_q == $past(in_q.speed))
    else $error("previous speed not taken from processed sample");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && therm_latch_d |=> out_q.pressure_out <= $past(cfg.clamp_max_pressure))
    else $error("main pressure above clamp while thermal latch set");

endmodule
